### hdl/ppd_pkg.sv
package ppd_pkg;

   localparam int POS_W  = 17;
   localparam int BASE_W = 10;
   localparam int BIT_W  = 19;
   localparam int WID_W  = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_ENC   = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   localparam logic [7:0] HDR_MAGIC0 = 8'hAA;
   localparam logic [7:0] HDR_MAGIC1 = 8'h0B;
   localparam logic [7:0] HDR_MAGIC3 = 8'hF4;
   localparam logic [7:0] ENC_TAG    = 8'h0C;

   localparam logic [BASE_W-1:0] HDR_BYTES      = 10'd8;
   localparam logic [BASE_W-1:0] PAL_FULL_BYTES = 10'd768;
   localparam logic [POS_W-1:0]  SOLID_LEN      = 17'd11;
   localparam logic [POS_W-1:0]  PC_RESET       = 17'd256;
   localparam int                SHADOW_BYTES   = 11;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_RESULT,
      OP_FETCH
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_LO,
      S_HI,
      S_CODE,
      S_RED,
      S_GREEN,
      S_BLUE
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [POS_W-1:0]    addr;
      logic [7:0]          data;
      logic [1:0]          status;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic [BASE_W-1:0]   base;
      logic [BIT_W-1:0]    bitpos;
      logic [WID_W-1:0]    width;
      logic [POS_W-1:0]    len;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [WID_W-1:0] index_width(input logic [7:0] n);
      logic [WID_W-1:0] w;
      w = 4'd8;
      if (n != 8'd0) begin
         w = 4'd0;
         for (int i = 0; i < 8; i++) begin
            if ((9'd1 << w) < {1'b0, n}) begin
               w = w + 4'd1;
            end
         end
      end
      return w;
   endfunction

endpackage

### hdl/palette_packed_pixel_decoder_top.sv
// Palette packed-pixel frame decoder.
// Request channel (req_valid / req_stall): req_cmd selects a frame byte load
// (req_data_byte, req_last) or a pixel decode (req_pixel_index). A load gives
// no response; a decode gives one response on rsp_valid / rsp_stall carrying
// rsp_red, rsp_green, rsp_blue and rsp_status.
// csr_valid / csr_ready writes pixel_count; csr_ready is always high.
// Requests enter a four-entry queue; a back-end sequencer owns the byte-wide
// frame memory and works through the queue in order.
// A decode settled from the header (short frame, bad encoding, index out of
// range, solid colour) is answered straight from its queue entry, one whose
// index lies past the stored data from S_CHECK. A decode that reads a palette
// entry steps S_CHECK, S_LO, S_HI (when the index spans two bytes), S_CODE,
// S_RED, S_GREEN, S_BLUE and occupies the sequencer meanwhile: the single memory
// port serves up to two index reads and three palette reads one at a time; a
// palette entry past the data ends it at S_CODE. A load is written as popped.
// Reset (synchronous): empties the queue, drops any pending response, marks
// the frame closed with zero bytes, sets pixel_count to 256. The frame memory
// is not cleared and needs no init pass.
// While rsp_stall is high the response holds; the queue keeps filling and
// req_stall rises once it is full.
module palette_packed_pixel_decoder_top #(
   parameter int FRAME_BYTES = 8192
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last,
   input  logic [15:0]               req_pixel_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [1:0]                rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ppd_pkg::POS_W-1:0] csr_pixel_count
);
   import ppd_pkg::*;

   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        head;
   queue_status_type q_status;

   assign req_stall = q_status.full;
   assign csr_ready = 1'b1;

   ppd_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_cmd         (req_cmd),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .req_pixel_index (req_pixel_index),
      .csr_valid       (csr_valid && csr_ready),
      .csr_pixel_count (csr_pixel_count),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   ppd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   ppd_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .rsp_status (rsp_status)
   );

endmodule

### hdl/ppd_front.sv
module ppd_front #(
   parameter int FRAME_BYTES = 8192
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_cmd,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last,
   input  logic [15:0]                req_pixel_index,
   input  logic                       csr_valid,
   input  logic [ppd_pkg::POS_W-1:0]  csr_pixel_count,
   input  ppd_pkg::queue_status_type  q_status,
   output logic                       push,
   output ppd_pkg::entry_type         push_entry
);
   import ppd_pkg::*;

   logic [POS_W-1:0]  count_ff, count_in;
   logic              closed_ff, closed_in;
   logic [POS_W-1:0]  pc_ff, pc_in;
   logic [7:0]        hdr_ff [SHADOW_BYTES];

   logic              accept;
   logic              is_load;
   logic [POS_W-1:0]  cur;
   logic              room;
   logic              over;
   logic              solid;
   logic [7:0]        n;
   logic [WID_W-1:0]  width;
   logic [BASE_W-1:0] base;

   always_comb begin
      accept  = req_valid && !q_status.full;
      is_load = (req_cmd == CMD_LOAD);
      cur     = closed_ff ? '0 : count_ff;
      room    = (cur < POS_W'(FRAME_BYTES));
      over    = ({1'b0, req_pixel_index} >= pc_ff);
      solid   = (count_ff == SOLID_LEN) && (hdr_ff[0] == HDR_MAGIC0)
                && (hdr_ff[1] == HDR_MAGIC1) && (hdr_ff[2] == 8'h00)
                && (hdr_ff[3] == HDR_MAGIC3) && (hdr_ff[4] == 8'h01)
                && (hdr_ff[5] == ENC_TAG) && (hdr_ff[6] == 8'h01)
                && (hdr_ff[7] == 8'h00);
      n       = hdr_ff[6];
      width   = index_width(n);
      base    = HDR_BYTES + ((n == 8'd0) ? PAL_FULL_BYTES : (BASE_W'(n) * 10'd3));

      push_entry        = '0;
      push_entry.addr   = cur;
      push_entry.data   = req_data_byte;
      push_entry.base   = base;
      push_entry.width  = width;
      push_entry.len    = count_ff;
      push_entry.bitpos = BIT_W'(width) * BIT_W'(req_pixel_index);

      if (is_load) begin
         push_entry.op = OP_WRITE;
      end else if (solid) begin
         push_entry.op = OP_RESULT;
         if (over) begin
            push_entry.status = ST_RANGE;
         end else begin
            push_entry.status = ST_OK;
            push_entry.red    = hdr_ff[8];
            push_entry.green  = hdr_ff[9];
            push_entry.blue   = hdr_ff[10];
         end
      end else if (count_ff < POS_W'(HDR_BYTES)) begin
         push_entry.op     = OP_RESULT;
         push_entry.status = ST_SHORT;
      end else if (hdr_ff[5] != ENC_TAG) begin
         push_entry.op     = OP_RESULT;
         push_entry.status = ST_ENC;
      end else if (over) begin
         push_entry.op     = OP_RESULT;
         push_entry.status = ST_RANGE;
      end else begin
         push_entry.op = OP_FETCH;
      end

      push = accept && (!is_load || room);

      count_in  = count_ff;
      closed_in = closed_ff;
      pc_in     = csr_valid ? csr_pixel_count : pc_ff;
      if (accept && is_load) begin
         closed_in = req_last;
         count_in  = room ? (cur + 1'b1) : cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         closed_ff <= 1'b1;
         pc_ff     <= PC_RESET;
      end else begin
         count_ff  <= count_in;
         closed_ff <= closed_in;
         pc_ff     <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_load && (cur < POS_W'(SHADOW_BYTES))) begin
         hdr_ff[cur[3:0]] <= req_data_byte;
      end
   end

endmodule

### hdl/ppd_queue.sv
module ppd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ppd_pkg::entry_type        push_entry,
   input  logic                      pop,
   output ppd_pkg::entry_type        head,
   output ppd_pkg::queue_status_type q_status
);
   import ppd_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   level_ff, level_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      q_status.empty = (level_ff == '0);
      q_status.full  = (level_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      do_push   = push && !q_status.full;
      do_pop    = pop && !q_status.empty;
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/ppd_back.sv
module ppd_back #(
   parameter int FRAME_BYTES = 8192
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ppd_pkg::entry_type        head,
   input  ppd_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [1:0]                rsp_status
);
   import ppd_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);

   logic [7:0]        mem [FRAME_BYTES];
   logic [7:0]        rdata_ff;

   back_state_type    state_ff, state_in;
   logic [POS_W-1:0]  at_ff, at_in;
   logic [2:0]        off_ff, off_in;
   logic [WID_W-1:0]  width_ff, width_in;
   logic [POS_W-1:0]  len_ff, len_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [7:0]        lo_ff, lo_in;
   logic [7:0]        hi_ff, hi_in;
   logic [BASE_W-1:0] cpos_ff, cpos_in;
   logic [7:0]        red_ff, red_in;
   logic [7:0]        green_ff, green_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [1:0]        rsp_status_ff;

   logic              out_free;
   logic              emit;
   logic [7:0]        emit_red, emit_green, emit_blue;
   logic [1:0]        emit_status;
   logic              wr_en;
   logic              rd_en;
   logic [POS_W-1:0]  rd_addr;
   logic              two;
   logic [POS_W-1:0]  at_next;
   logic [15:0]       word;
   logic [7:0]        mask;
   logic [7:0]        code;
   logic [BASE_W-1:0] cpos;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      two      = (({1'b0, off_ff}) + width_ff) > 4'd8;
      at_next  = at_ff + 1'b1;
      word     = {hi_ff, lo_ff} >> off_ff;
      mask     = 8'((9'd1 << width_ff) - 9'd1);
      code     = word[7:0] & mask;
      cpos     = HDR_BYTES + (BASE_W'(code) * 10'd3);

      state_in    = state_ff;
      at_in       = at_ff;
      off_in      = off_ff;
      width_in    = width_ff;
      len_in      = len_ff;
      base_in     = base_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      cpos_in     = cpos_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = at_ff;
      emit        = 1'b0;
      emit_red    = 8'd0;
      emit_green  = 8'd0;
      emit_blue   = 8'd0;
      emit_status = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               case (head.op)
                  OP_WRITE: begin
                     pop   = 1'b1;
                     wr_en = 1'b1;
                  end
                  OP_RESULT: begin
                     if (out_free) begin
                        pop         = 1'b1;
                        emit        = 1'b1;
                        emit_red    = head.red;
                        emit_green  = head.green;
                        emit_blue   = head.blue;
                        emit_status = head.status;
                     end
                  end
                  OP_FETCH: begin
                     pop      = 1'b1;
                     at_in    = POS_W'(head.base) + POS_W'(head.bitpos[BIT_W-1:3]);
                     off_in   = head.bitpos[2:0];
                     width_in = head.width;
                     len_in   = head.len;
                     base_in  = head.base;
                     state_in = S_CHECK;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if ((POS_W'(base_ff) >= len_ff) || (at_ff >= len_ff)
                || (two && (at_next >= len_ff))) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = at_ff;
               state_in = S_LO;
            end
         end
         S_LO: begin
            lo_in = rdata_ff;
            if (two) begin
               rd_en    = 1'b1;
               rd_addr  = at_next;
               state_in = S_HI;
            end else begin
               state_in = S_CODE;
            end
         end
         S_HI: begin
            hi_in    = rdata_ff;
            state_in = S_CODE;
         end
         S_CODE: begin
            cpos_in = cpos;
            if ((POS_W'(cpos) + 17'd2) < len_ff) begin
               rd_en    = 1'b1;
               rd_addr  = POS_W'(cpos);
               state_in = S_RED;
            end else if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RED: begin
            red_in   = rdata_ff;
            rd_en    = 1'b1;
            rd_addr  = POS_W'(cpos_ff) + 17'd1;
            state_in = S_GREEN;
         end
         S_GREEN: begin
            green_in = rdata_ff;
            rd_en    = 1'b1;
            rd_addr  = POS_W'(cpos_ff) + 17'd2;
            state_in = S_BLUE;
         end
         S_BLUE: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_red   = red_ff;
               emit_green = green_ff;
               emit_blue  = rdata_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      at_ff    <= at_in;
      off_ff   <= off_in;
      width_ff <= width_in;
      len_ff   <= len_in;
      base_ff  <= base_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      cpos_ff  <= cpos_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      if (emit) begin
         rsp_red_ff    <= emit_red;
         rsp_green_ff  <= emit_green;
         rsp_blue_ff   <= emit_blue;
         rsp_status_ff <= emit_status;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[head.addr[AW-1:0]] <= head.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_red    = rsp_red_ff;
   assign rsp_green  = rsp_green_ff;
   assign rsp_blue   = rsp_blue_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### hdl/ppd_checker.sv
module ppd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [1:0] rsp_status
);
   import ppd_pkg::*;

   a_reset_drops_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_error_is_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK))
      |-> ((rsp_red == 8'd0) && (rsp_green == 8'd0) && (rsp_blue == 8'd0)))
      else $error("error response carries a colour");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && rsp_stall)
      |=> (rsp_valid && $stable(rsp_red) && $stable(rsp_green)
           && $stable(rsp_blue) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind palette_packed_pixel_decoder_top ppd_checker u_ppd_checker (.*);
